// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the stack unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clock, quiet while reset is high.
`define LSS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define LSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/lss_pkg.sv
// Package of the stack unit: widths, operation and status codes, default depth.
package lss_pkg;

   localparam int unsigned LSS_DEPTH = 256;
   localparam int unsigned OP_W      = 2;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned WORD_W    = 32;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_SEEK = 2'd3
   } lss_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } lss_status_type;

endpackage

// File: rtl/lss_store.sv
// Entry memory of the stack unit: one write port, one registered read port, key compare.
module lss_store #(
   parameter int unsigned DEPTH = lss_pkg::LSS_DEPTH,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [AW-1:0]                     wr_addr,
   input  logic signed [lss_pkg::WORD_W-1:0] wr_data,
   input  logic [AW-1:0]                     rd_addr,
   input  logic signed [lss_pkg::WORD_W-1:0] key,
   output logic signed [lss_pkg::WORD_W-1:0] rd_data,
   output logic                              hit
);
   import lss_pkg::*;

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   // entry read last cycle against the word being sought
   assign hit     = (rd_data_ff == key);

endmodule

// File: rtl/lifo_stack_with_search_unit.sv
// Top level of the stack unit: request decode, fill count, seek walk, result register.
//
//   channel   ports                                       handshake
//   request   req_opcode, req_operand_value               start high while busy low
//   result    rsp_status, rsp_top_value                   rsp_strobe, one cycle
//
// Push and pop show their result the cycle after acceptance
// and busy stays low, so another item may follow at once.
// Peek of a held entry waits in S_PEEK for the registered memory read and is busy there.
// Seek reads one entry a cycle from the top down through the single read port,
// busy until an entry hits or the bottom entry has missed.
// Reset empties the store at once; entries are not cleared. Results cannot be stalled.
`include "assert_macros.svh"

module lifo_stack_with_search_unit #(
   parameter int unsigned DEPTH = lss_pkg::LSS_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lss_pkg::OP_W-1:0]            req_opcode,
   input  logic signed [lss_pkg::WORD_W-1:0]   req_operand_value,
   output logic                                rsp_strobe,
   output logic [lss_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [lss_pkg::WORD_W-1:0]   rsp_top_value
);
   import lss_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_PEEK = 3'b010,
      S_SEEK = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            ptr_ff, ptr_in;
   logic signed [WORD_W-1:0] key_ff, key_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   lss_status_type           rsp_status_ff, rsp_status_in;
   logic signed [WORD_W-1:0] rsp_top_value_ff, rsp_top_value_in;

   logic                     accept;
   logic                     is_empty;
   logic                     is_full;
   logic [CW-1:0]            cnt_dec;
   logic [AW-1:0]            ptr_dec;
   logic                     wr_en;
   logic [AW-1:0]            rd_addr;
   logic signed [WORD_W-1:0] rd_data;
   logic                     hit;
   logic                     acc_push_pop;
   logic                     seek_step;
   logic                     shows_value;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CW'(DEPTH));
   assign cnt_dec  = count_ff - 1'b1;
   assign ptr_dec  = ptr_ff - 1'b1;

   lss_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_operand_value),
      .rd_addr (rd_addr),
      .key     (key_ff),
      .rd_data (rd_data),
      .hit     (hit)
   );

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      ptr_in           = ptr_ff;
      key_in           = key_ff;
      rsp_strobe_in    = 1'b0;
      rsp_status_in    = ST_OK;
      rsp_top_value_in = '0;
      wr_en            = 1'b0;
      rd_addr          = cnt_dec[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (lss_op_type'(req_opcode))
                  OP_PUSH: begin
                     rsp_strobe_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     rsp_strobe_in = 1'b1;
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        count_in = cnt_dec;
                     end
                  end
                  OP_PEEK: begin
                     if (is_empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        state_in = S_PEEK;
                     end
                  end
                  OP_SEEK: begin
                     if (is_empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        key_in   = req_operand_value;
                        ptr_in   = cnt_dec[AW-1:0];
                        state_in = S_SEEK;
                     end
                  end
               endcase
            end
         end
         S_PEEK: begin
            rsp_strobe_in    = 1'b1;
            rsp_top_value_in = rd_data;
            state_in         = S_IDLE;
         end
         S_SEEK: begin
            // rd_data holds the entry at ptr_ff; fetch the one below meanwhile
            rd_addr = ptr_dec;
            if (hit) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else if (ptr_ff == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_NOT_FOUND;
               state_in      = S_IDLE;
            end else begin
               ptr_in = ptr_dec;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff           <= ptr_in;
      key_ff           <= key_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_top_value_ff <= rsp_top_value_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_top_value = rsp_top_value_ff;

   assign acc_push_pop = accept && (req_opcode == OP_PUSH || req_opcode == OP_POP);
   assign seek_step    = (state_ff == S_SEEK) && !hit && (ptr_ff != '0);
   assign shows_value  = rsp_strobe_ff && (rsp_top_value_ff != '0);

   `LSS_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "fill count beyond depth")
   `LSS_ASSERT_NEXT(a_push_pop_one_cycle, acc_push_pop, rsp_strobe_ff && !busy, "push/pop late")
   `LSS_ASSERT_NEXT(a_push_count, wr_en, count_ff == $past(count_ff) + 1'b1, "push lost")
   `LSS_ASSERT_NEXT(a_seek_quiet, seek_step, !rsp_strobe_ff && state_ff == S_SEEK, "seek early")
   `LSS_ASSERT(a_value_only_ok, !shows_value || rsp_status_ff == ST_OK, "value with bad status")

endmodule
